### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion shorthands for the allocator checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, held off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/core/ffa_pkg.sv
// ----------------------------------------------------------------------------
// ffa_pkg
// types, codes and controller/datapath command words for the extent allocator
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int BASE_W = 32;
    localparam int LEN_W  = 25;

    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_MEM  = 2'd1;
    localparam logic [1:0] ST_BAD_LEN = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [BASE_W-1:0] region_base;
        logic [LEN_W-1:0]  region_length;
    } req_t;

    typedef struct packed {
        logic [BASE_W-1:0] granted_base;
        logic [1:0]        status;
    } rsp_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_IDX,
        RD_IDX1,
        RD_KM1,
        RD_KP1
    } rd_sel_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_SHRINK,
        WR_FRONT,
        WR_BACK,
        WR_JOIN,
        WR_MOVE,
        WR_NEW
    } wr_op_t;

    typedef enum logic [2:0] {
        K_HOLD,
        K_COUNT,
        K_IDX,
        K_IDX1,
        K_INC,
        K_DEC
    } k_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        G_HOLD,
        G_EXACT,
        G_TAIL
    } grant_op_t;

    typedef struct packed {
        logic      capture;
        logic      idx_inc;
        rd_sel_t   rd_sel;
        wr_op_t    wr_op;
        k_op_t     k_op;
        cnt_op_t   cnt_op;
        grant_op_t grant_op;
        logic      examine;
        logic      finish;
        logic [1:0] status;
    } cmd_t;

    typedef struct packed {
        logic mode;
        logic bad_len;
        logic at_end;
        logic full;
        logic k_at_idx;
        logic k_last;
        logic fit_eq;
        logic fit_gt;
        logic above;
        logic meets_end;
        logic back_touch;
        logic join_ok;
        logic ovf_solo;
        logic ovf_join;
    } flags_t;

endpackage

### rtl/core/ffa_datapath.sv
// ----------------------------------------------------------------------------
// ffa_datapath
// extent table memory, walk/shift pointers, adders and result register
// ----------------------------------------------------------------------------
module ffa_datapath
    import ffa_pkg::*;
#(
    parameter int               EXTENT_SLOTS = 16,
    parameter logic [LEN_W-1:0] LEN_LIMIT    = LEN_MAX
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  req_t   req,
    input  cmd_t   cmd,
    output flags_t flags,
    output rsp_t   rsp
);

    localparam int IW = $clog2(EXTENT_SLOTS);
    localparam int CW = $clog2(EXTENT_SLOTS + 1);

    logic [BASE_W-1:0] mem_base [EXTENT_SLOTS];
    logic [LEN_W-1:0]  mem_len  [EXTENT_SLOTS];

    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     k_reg, k_next;

    logic              mode_reg;
    logic [BASE_W-1:0] base_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [BASE_W-1:0] pend_reg;
    logic [BASE_W-1:0] rd_base_reg;
    logic [LEN_W-1:0]  rd_len_reg;
    logic [LEN_W:0]    sum_reg;
    logic [LEN_W-1:0]  diff_reg;
    logic [BASE_W-1:0] grant_reg, grant_next;
    rsp_t              rsp_reg;

    logic [CW-1:0]     raddr_full;
    logic              rd_en;
    logic [CW-1:0]     waddr_full;
    logic              wr_base_en;
    logic              wr_len_en;
    logic [BASE_W-1:0] wr_base;
    logic [LEN_W-1:0]  wr_len;
    logic [LEN_W+1:0]  join_sum;
    logic [BASE_W-1:0] rd_end;

    assign join_sum = {1'b0, sum_reg} + {2'b00, rd_len_reg};
    assign rd_end   = rd_base_reg + {{(BASE_W-LEN_W){1'b0}}, rd_len_reg};

    // status towards the controller
    always_comb
    begin
        flags.mode       = mode_reg;
        flags.bad_len    = (len_reg == '0) || (len_reg > LEN_LIMIT);
        flags.at_end     = (idx_reg == count_reg);
        flags.full       = (count_reg == CW'(EXTENT_SLOTS));
        flags.k_at_idx   = (k_reg == idx_reg);
        flags.k_last     = ((k_reg + CW'(1)) == count_reg);
        flags.fit_eq     = (rd_len_reg == len_reg);
        flags.fit_gt     = (rd_len_reg > len_reg);
        flags.above      = (rd_base_reg > pend_reg);
        flags.meets_end  = (rd_base_reg == pend_reg);
        flags.back_touch = (rd_end == base_reg);
        flags.join_ok    = ((idx_reg + CW'(1)) < count_reg);
        flags.ovf_solo   = sum_reg[LEN_W];
        flags.ovf_join   = |join_sum[LEN_W+1:LEN_W];
    end

    // read address select
    always_comb
    begin
        rd_en      = 1'b1;
        raddr_full = idx_reg;
        unique case (cmd.rd_sel)
            RD_NONE: rd_en      = 1'b0;
            RD_IDX:  raddr_full = idx_reg;
            RD_IDX1: raddr_full = idx_reg + CW'(1);
            RD_KM1:  raddr_full = k_reg - CW'(1);
            RD_KP1:  raddr_full = k_reg + CW'(1);
            default: rd_en      = 1'b0;
        endcase
    end

    // write port select
    always_comb
    begin
        wr_base_en = 1'b0;
        wr_len_en  = 1'b0;
        waddr_full = idx_reg;
        wr_base    = rd_base_reg;
        wr_len     = rd_len_reg;
        unique case (cmd.wr_op)
            WR_NONE: ;
            WR_SHRINK:
            begin
                wr_len_en = 1'b1;
                wr_len    = diff_reg;
            end
            WR_FRONT:
            begin
                wr_base_en = 1'b1;
                wr_len_en  = 1'b1;
                wr_base    = base_reg;
                wr_len     = sum_reg[LEN_W-1:0];
            end
            WR_BACK:
            begin
                wr_len_en = 1'b1;
                wr_len    = sum_reg[LEN_W-1:0];
            end
            WR_JOIN:
            begin
                wr_len_en = 1'b1;
                wr_len    = join_sum[LEN_W-1:0];
            end
            WR_MOVE:
            begin
                wr_base_en = 1'b1;
                wr_len_en  = 1'b1;
                waddr_full = k_reg;
            end
            WR_NEW:
            begin
                wr_base_en = 1'b1;
                wr_len_en  = 1'b1;
                wr_base    = base_reg;
                wr_len     = len_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_base_en)
        begin
            mem_base[waddr_full[IW-1:0]] <= wr_base;
        end
        if (wr_len_en)
        begin
            mem_len[waddr_full[IW-1:0]] <= wr_len;
        end
        if (rd_en)
        begin
            rd_base_reg <= mem_base[raddr_full[IW-1:0]];
            rd_len_reg  <= mem_len[raddr_full[IW-1:0]];
        end
    end

    always_comb
    begin
        k_next = k_reg;
        unique case (cmd.k_op)
            K_HOLD:  k_next = k_reg;
            K_COUNT: k_next = count_reg;
            K_IDX:   k_next = idx_reg;
            K_IDX1:  k_next = idx_reg + CW'(1);
            K_INC:   k_next = k_reg + CW'(1);
            K_DEC:   k_next = k_reg - CW'(1);
            default: k_next = k_reg;
        endcase

        count_next = count_reg;
        unique case (cmd.cnt_op)
            CNT_HOLD: count_next = count_reg;
            CNT_INC:  count_next = count_reg + CW'(1);
            CNT_DEC:  count_next = count_reg - CW'(1);
            default:  count_next = count_reg;
        endcase

        idx_next = idx_reg;
        if (cmd.capture)
        begin
            idx_next = '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_next = idx_reg + CW'(1);
        end

        grant_next = grant_reg;
        if (cmd.capture)
        begin
            grant_next = '0;
        end
        else
        begin
            unique case (cmd.grant_op)
                G_HOLD:  grant_next = grant_reg;
                G_EXACT: grant_next = rd_base_reg;
                G_TAIL:  grant_next = rd_base_reg + {{(BASE_W-LEN_W){1'b0}}, diff_reg};
                default: grant_next = grant_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            k_reg     <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
            k_reg     <= k_next;
        end
    end

    // request, arithmetic and result words
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= req.mode;
            base_reg <= req.region_base;
            len_reg  <= req.region_length;
            pend_reg <= req.region_base
                        + {{(BASE_W-LEN_W){1'b0}}, req.region_length};
        end
        if (cmd.examine)
        begin
            sum_reg  <= {1'b0, len_reg} + {1'b0, rd_len_reg};
            diff_reg <= rd_len_reg - len_reg;
        end
        grant_reg <= grant_next;
        if (cmd.finish)
        begin
            rsp_reg.granted_base <= grant_next;
            rsp_reg.status       <= cmd.status;
        end
    end

    assign rsp = rsp_reg;

endmodule

### rtl/core/ffa_ctrl.sv
// ----------------------------------------------------------------------------
// ffa_ctrl
// sequencer for first-fit walk, merge decision and table shifts
// ----------------------------------------------------------------------------
module ffa_ctrl
    import ffa_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   start,
    input  flags_t flags,
    output cmd_t   cmd,
    output logic   busy,
    output logic   done
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_A_READ,
        S_A_EXAM,
        S_A_SHRINK,
        S_DN_READ,
        S_DN_WRITE,
        S_F_READ,
        S_F_EXAM,
        S_F_DECIDE,
        S_F_JOIN,
        S_F_INSERT,
        S_UP_READ,
        S_UP_WRITE
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.rd_sel   = RD_NONE;
        cmd.wr_op    = WR_NONE;
        cmd.k_op     = K_HOLD;
        cmd.cnt_op   = CNT_HOLD;
        cmd.grant_op = G_HOLD;
        cmd.status   = ST_OK;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (flags.bad_len)
                begin
                    cmd.finish = 1'b1;
                    cmd.status = ST_BAD_LEN;
                    state_next = S_IDLE;
                end
                else if (flags.mode == MODE_ALLOC)
                begin
                    state_next = S_A_READ;
                end
                else
                begin
                    state_next = S_F_READ;
                end
            end
            S_A_READ:
            begin
                if (flags.at_end)
                begin
                    cmd.finish = 1'b1;
                    cmd.status = ST_NO_MEM;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_sel = RD_IDX;
                    state_next = S_A_EXAM;
                end
            end
            S_A_EXAM:
            begin
                priority if (flags.fit_eq)
                begin
                    // exact fit: grant the base, then close the gap
                    cmd.grant_op = G_EXACT;
                    cmd.k_op     = K_IDX;
                    state_next   = S_DN_READ;
                end
                else if (flags.fit_gt)
                begin
                    cmd.examine = 1'b1;
                    state_next  = S_A_SHRINK;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_A_READ;
                end
            end
            S_A_SHRINK:
            begin
                cmd.wr_op    = WR_SHRINK;
                cmd.grant_op = G_TAIL;
                cmd.finish   = 1'b1;
                state_next   = S_IDLE;
            end
            S_DN_READ:
            begin
                if (flags.k_last)
                begin
                    cmd.cnt_op = CNT_DEC;
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_sel = RD_KP1;
                    state_next = S_DN_WRITE;
                end
            end
            S_DN_WRITE:
            begin
                cmd.wr_op  = WR_MOVE;
                cmd.k_op   = K_INC;
                state_next = S_DN_READ;
            end
            S_F_READ:
            begin
                if (flags.at_end)
                begin
                    state_next = S_F_INSERT;
                end
                else
                begin
                    cmd.rd_sel = RD_IDX;
                    state_next = S_F_EXAM;
                end
            end
            S_F_EXAM:
            begin
                if (flags.above)
                begin
                    state_next = S_F_INSERT;
                end
                else
                begin
                    cmd.examine = 1'b1;
                    state_next  = S_F_DECIDE;
                end
            end
            S_F_DECIDE:
            begin
                priority if (flags.meets_end)
                begin
                    // entry starts where the range ends: it absorbs the range
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                    if (flags.ovf_solo)
                    begin
                        cmd.status = ST_BAD_LEN;
                    end
                    else
                    begin
                        cmd.wr_op = WR_FRONT;
                    end
                end
                else if (flags.back_touch)
                begin
                    if (flags.join_ok)
                    begin
                        cmd.rd_sel = RD_IDX1;
                    end
                    state_next = S_F_JOIN;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = S_F_READ;
                end
            end
            S_F_JOIN:
            begin
                if (flags.join_ok && flags.meets_end)
                begin
                    // range bridges two entries: grow the lower, drop the upper
                    if (flags.ovf_join)
                    begin
                        cmd.finish = 1'b1;
                        cmd.status = ST_BAD_LEN;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.wr_op  = WR_JOIN;
                        cmd.k_op   = K_IDX1;
                        state_next = S_DN_READ;
                    end
                end
                else
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                    if (flags.ovf_solo)
                    begin
                        cmd.status = ST_BAD_LEN;
                    end
                    else
                    begin
                        cmd.wr_op = WR_BACK;
                    end
                end
            end
            S_F_INSERT:
            begin
                if (flags.full)
                begin
                    cmd.finish = 1'b1;
                    cmd.status = ST_FULL;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.k_op   = K_COUNT;
                    state_next = S_UP_READ;
                end
            end
            S_UP_READ:
            begin
                if (flags.k_at_idx)
                begin
                    cmd.wr_op  = WR_NEW;
                    cmd.cnt_op = CNT_INC;
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_sel = RD_KM1;
                    state_next = S_UP_WRITE;
                end
            end
            S_UP_WRITE:
            begin
                cmd.wr_op  = WR_MOVE;
                cmd.k_op   = K_DEC;
                state_next = S_UP_READ;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        done_next = cmd.finish;
    end

    // exact fit reuses the shift-down loop starting at the hit entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule

### rtl/core/first_fit_extent_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_extent_allocator_unit
// first-fit extent allocator with coalescing free over a sorted extent table
// ----------------------------------------------------------------------------
//  channel   ports                 handshake
//  request   start, busy, req      taken on start && !busy
//  result    done, rsp             done high one cycle, no back-pressure
//
//  one request at a time; busy from the accepting edge until the result edge
//  alloc: walks entries in order to the first that is long enough; shrinks it,
//        or on an exact fit grants it and shifts the later entries down
//  free: passes entries below the range, then merges, inserts or reports full,
//        shifting entries on insert or join
//  worst case is a free walking a full table; table is empty after reset, no
//  clearing pass; a new start is taken in the cycle that done is shown
// ----------------------------------------------------------------------------
module first_fit_extent_allocator_unit
    import ffa_pkg::*;
#(
    parameter int EXTENT_SLOTS = 16,
    parameter int PAGES        = 4096,
    parameter int PAGE_BYTES   = 4096
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t req,
    output logic done,
    output rsp_t rsp
);

    localparam logic [63:0] POOL_BYTES = 64'(PAGES) * 64'(PAGE_BYTES);
    localparam logic [LEN_W-1:0] LEN_LIMIT =
        (POOL_BYTES > 64'(LEN_MAX)) ? LEN_MAX : POOL_BYTES[LEN_W-1:0];

    cmd_t   cmd;
    flags_t flags;

    ffa_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    ffa_datapath #(
        .EXTENT_SLOTS (EXTENT_SLOTS),
        .LEN_LIMIT    (LEN_LIMIT)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .flags (flags),
        .rsp   (rsp)
    );

endmodule

### rtl/core/ffa_checker.sv
// ----------------------------------------------------------------------------
// ffa_checker
// port-level checks on request/result sequencing of the allocator
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ffa_checker
    import ffa_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input req_t req,
    input logic done,
    input rsp_t rsp
);

    logic req_unused;
    logic failed;

    assign req_unused = ^req;
    assign failed     = (rsp.status != ST_OK) && !req_unused && !(req_unused === 1'b1)
                        || (rsp.status != ST_OK);

    `ASSERT_NEXT(a_take_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_IMPLY(a_done_idle, clk, rst_n, done, !busy)
    `ASSERT_IMPLY(a_busy_fall_done, clk, rst_n, $fell(busy), done)
    `ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    `ASSERT_IMPLY(a_fail_zero, clk, rst_n, done && failed, rsp.granted_base == '0)

endmodule

bind first_fit_extent_allocator_unit ffa_checker u_ffa_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .req   (req),
    .done  (done),
    .rsp   (rsp)
);
